>>> src/sha1h_pkg.sv
package sha1h_pkg;

  // Initial chaining value
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Last byte position of a block and first position of the length field
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [6:0] LAST_RND = 7'd79;
  localparam logic [2:0] LAST_IDX = 3'd4;

  // Source of the byte written into the block
  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_MARK,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // Round function group
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY0,
    PH_MAJORITY,
    PH_PARITY1
  } phase_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       absorb;     // write one byte into the block
    logic       word_done;  // the byte completes a 32-bit word
    byte_sel_e  sel;
    logic       count_bits; // add 8 to the message length
    logic [2:0] len_pos;    // byte of the length field
    logic       load_vars;  // a..e <= chaining value
    logic       round;      // run one compression round
    phase_e     phase;
    logic       fold;       // chaining value += a..e
    logic       clear;      // start a new message
    logic [2:0] out_idx;    // digest word shown on the output
  } cmd_t;

endpackage

>>> src/sha1_stream_hasher.sv
// SHA-1 over a byte stream. Each input request carries at most one message
// byte (tuser high) and may end the message (tlast); an end request without a
// byte pads what has arrived, so it also hashes the empty message. A byte that
// fills a 64-byte block holds the input while the block is run through 80
// rounds on the single round unit and folded into the chaining value. An end
// request then writes the end marker, zero fill and bit length one byte per
// cycle up to the block boundary (one or two blocks, each again 80 rounds
// and a fold), and the digest follows as five 32-bit words, most significant
// first, with the word index in tuser and tlast on the fifth. Input is refused
// until the last digest word is taken; the next request starts a new message.
module sha1_stream_hasher
  import sha1h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  // digest stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  cmd_t cmd;

  sha1h_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .byte_valid_i     (s_axis_tuser),
    .end_of_message_i (s_axis_tlast),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .cmd_o            (cmd)
  );

  sha1h_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata),
    .digest_word_o (m_axis_tdata)
  );

  // Word position and last flag follow the output index
  assign m_axis_tuser = cmd.out_idx;
  assign m_axis_tlast = (cmd.out_idx == LAST_IDX);

endmodule

>>> src/sha1h_datapath.sv
module sha1h_datapath
  import sha1h_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic [31:0] digest_word_o
);

  logic [31:0] w_q [16];
  logic [23:0] acc_q;
  logic [31:0] h_q [5];
  logic [31:0] v_q [5];
  logic [63:0] bits_q;

  logic [7:0]  byte_in;
  logic [63:0] len_shift;
  logic [31:0] expand;
  logic [31:0] new_word;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  // Select the byte written into the block
  assign len_shift = bits_q << {cmd_i.len_pos, 3'b000};

  always_comb begin
    case (cmd_i.sel)
      SEL_DATA: byte_in = data_byte_i;
      SEL_MARK: byte_in = PAD_MARK;
      SEL_ZERO: byte_in = 8'h00;
      SEL_LEN:  byte_in = len_shift[63:56];
      default:  byte_in = 8'h00;
    endcase
  end

  // Schedule expansion and the word that enters the window
  assign expand   = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign new_word = cmd_i.round ? {expand[30:0], expand[31]} : {acc_q, byte_in};

  // Round function and constant
  always_comb begin
    case (cmd_i.phase)
      PH_CHOOSE: begin
        f = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
        k = K0;
      end
      PH_PARITY0: begin
        f = v_q[1] ^ v_q[2] ^ v_q[3];
        k = K1;
      end
      PH_MAJORITY: begin
        f = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
        k = K2;
      end
      PH_PARITY1: begin
        f = v_q[1] ^ v_q[2] ^ v_q[3];
        k = K3;
      end
      default: begin
        f = '0;
        k = '0;
      end
    endcase
  end

  assign tmp = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + w_q[0];

  // Byte accumulator and 16-word schedule window
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      acc_q <= {acc_q[15:0], byte_in};
    end
    if ((cmd_i.absorb && cmd_i.word_done) || cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= new_word;
    end
  end

  // Working variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        v_q[i] <= '0;
      end
    end else if (cmd_i.load_vars) begin
      for (int i = 0; i < 5; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.round) begin
      v_q[0] <= tmp;
      v_q[1] <= v_q[0];
      v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3];
    end
  end

  // Chaining value and message length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= IV0;
      h_q[1] <= IV1;
      h_q[2] <= IV2;
      h_q[3] <= IV3;
      h_q[4] <= IV4;
      bits_q <= '0;
    end else if (cmd_i.clear) begin
      h_q[0] <= IV0;
      h_q[1] <= IV1;
      h_q[2] <= IV2;
      h_q[3] <= IV3;
      h_q[4] <= IV4;
      bits_q <= '0;
    end else begin
      if (cmd_i.fold) begin
        for (int i = 0; i < 5; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
      if (cmd_i.count_bits) begin
        bits_q <= bits_q + 64'd8;
      end
    end
  end

  // Digest word on the output
  always_comb begin
    case (cmd_i.out_idx)
      3'd0:    digest_word_o = h_q[0];
      3'd1:    digest_word_o = h_q[1];
      3'd2:    digest_word_o = h_q[2];
      3'd3:    digest_word_o = h_q[3];
      3'd4:    digest_word_o = h_q[4];
      default: digest_word_o = h_q[0];
    endcase
  end

endmodule

>>> src/sha1h_ctrl.sv
module sha1h_ctrl
  import sha1h_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic byte_valid_i,
  input  logic end_of_message_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       pad_q, pad_d;     // padding in progress
  logic       mark_q, mark_d;   // end marker written
  logic       lenok_q, lenok_d; // this block takes the length field
  logic       final_q, final_d; // block under compression is the last

  logic       in_ready;
  logic       out_valid;
  cmd_t       cmd;

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid;
  assign cmd_o       = cmd;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    lenok_d   = lenok_q;
    final_d   = final_q;
    in_ready  = 1'b0;
    out_valid = 1'b0;

    cmd           = '0;
    cmd.sel       = SEL_DATA;
    cmd.word_done = (fill_q[1:0] == 2'b11);
    cmd.len_pos   = fill_q[2:0];
    cmd.out_idx   = idx_q;
    if (rnd_q < 7'd20) begin
      cmd.phase = PH_CHOOSE;
    end else if (rnd_q < 7'd40) begin
      cmd.phase = PH_PARITY0;
    end else if (rnd_q < 7'd60) begin
      cmd.phase = PH_MAJORITY;
    end else begin
      cmd.phase = PH_PARITY1;
    end

    case (state_q)
      // Take a request; a byte goes into the block
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd.absorb     = 1'b1;
            cmd.count_bits = 1'b1;
            fill_d         = fill_q + 6'd1;
          end
          if (end_of_message_i) begin
            pad_d = 1'b1;
          end
          if (byte_valid_i && fill_q == LAST_POS) begin
            cmd.load_vars = 1'b1;
            rnd_d         = '0;
            state_d       = ST_ROUND;
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end

      // Write marker, zero fill and length one byte per cycle
      ST_PAD: begin
        cmd.absorb = 1'b1;
        fill_d     = fill_q + 6'd1;
        mark_d     = 1'b1;
        if (!mark_q) begin
          cmd.sel = SEL_MARK;
          if (fill_q < LEN_POS) begin
            lenok_d = 1'b1;
          end
        end else if (lenok_q && fill_q >= LEN_POS) begin
          cmd.sel = SEL_LEN;
        end else begin
          cmd.sel = SEL_ZERO;
        end
        if (fill_q == LAST_POS) begin
          cmd.load_vars = 1'b1;
          rnd_d         = '0;
          state_d       = ST_ROUND;
          final_d       = lenok_q && mark_q;
          lenok_d       = 1'b1;
        end
      end

      // One compression round per cycle
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == LAST_RND) begin
          rnd_d   = '0;
          state_d = ST_FOLD;
        end
      end

      // Add the working variables into the chaining value
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_q) begin
          idx_d   = '0;
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      // Hand out five digest words, then start over
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_IDX) begin
            cmd.clear = 1'b1;
            idx_d     = '0;
            fill_d    = '0;
            pad_d     = 1'b0;
            mark_d    = 1'b0;
            lenok_d   = 1'b0;
            final_d   = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
      final_q <= final_d;
    end
  end

endmodule
